/* design/srfe_pkg.sv */
`default_nettype none

package srfe_pkg;

	localparam int CH_W    = 10;
	localparam int NCH     = 4;
	localparam int STEP_W  = 8;
	localparam int FP_W    = 16;
	localparam int MUL_W   = 18;
	localparam int PROD_W  = 34;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// highest channel level; targets above it are clamped on entry
	localparam int LEVEL_MAX = 1023;

	// 3 * 65535, the constant term of the (3 - 2t) factor of the smoothstep polynomial
	localparam logic [MUL_W-1:0] FP_THREE = 18'd196605;

	localparam logic [1:0] KIND_ONOFF = 2'd0;
	localparam logic [1:0] KIND_LEVEL = 2'd1;
	localparam logic [1:0] KIND_COLOR = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam logic [2:0] REG_FADE_EN     = 3'd0;
	localparam logic [2:0] REG_STEPS_ON    = 3'd1;
	localparam logic [2:0] REG_STEPS_OFF   = 3'd2;
	localparam logic [2:0] REG_STEPS_LEVEL = 3'd3;
	localparam logic [2:0] REG_STEPS_COLOR = 3'd4;

	localparam logic [STEP_W-1:0] RST_STEPS_ON    = 8'd50;
	localparam logic [STEP_W-1:0] RST_STEPS_OFF   = 8'd35;
	localparam logic [STEP_W-1:0] RST_STEPS_LEVEL = 8'd32;
	localparam logic [STEP_W-1:0] RST_STEPS_COLOR = 8'd65;

	typedef logic [NCH-1:0][CH_W-1:0] color_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ISSUE,
		S_WAIT,
		S_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		OP_T2,
		OP_S,
		OP_CH
	} mul_op_t;

	typedef struct packed {
		logic              go;
		logic [STEP_W-1:0] step;
		logic [STEP_W-1:0] total;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [FP_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic             go;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic            done;
		logic [FP_W-1:0] q;
	} mul_rsp_t;

endpackage

`default_nettype wire

/* design/srfe_div.sv */
`default_nettype none

module srfe_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srfe_pkg::div_req_t req,
	output srfe_pkg::div_rsp_t      rsp
);
	import srfe_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [3:0]        cnt_q;
	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] dvs_q;
	logic [FP_W-1:0]   num_q;

	logic [STEP_W+FP_W-1:0] dividend;
	logic [STEP_W:0]        trial;
	logic                   ge;
	logic [STEP_W-1:0]      rem_nx;

	// step * 65535; the top byte is already below the divisor, so 16 steps suffice
	assign dividend = {req.step, {FP_W{1'b0}}} - {{FP_W{1'b0}}, req.step};
	assign trial    = {rem_q, num_q[FP_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign rem_nx   = ge ? STEP_W'(trial - {1'b0, dvs_q}) : trial[STEP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(FP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= dividend[STEP_W+FP_W-1:FP_W];
			num_q <= dividend[FP_W-1:0];
			dvs_q <= req.total;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			num_q <= {num_q[FP_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

`default_nettype wire

/* design/srfe_mulq.sv */
`default_nettype none

module srfe_mulq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srfe_pkg::mul_req_t req,
	output srfe_pkg::mul_rsp_t      rsp
);
	import srfe_pkg::*;

	// floor(x / 65535): fold the high part twice, then one correction
	function automatic logic [MUL_W:0] div_fp_one(input logic [PROD_W-1:0] x);
		logic [MUL_W:0] r1;
		logic [2:0]     hi2;
		logic [FP_W:0]  r2;
		logic           c;
		r1  = {1'b0, x[PROD_W-1:FP_W]} + {3'b0, x[FP_W-1:0]};
		hi2 = r1[MUL_W:FP_W];
		r2  = {1'b0, r1[FP_W-1:0]} + {14'b0, hi2};
		c   = r2 >= 17'd65535;
		return {1'b0, x[PROD_W-1:FP_W]} + {16'b0, hi2} + {18'b0, c};
	endfunction

	logic              valid_s1;
	logic              valid_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [FP_W-1:0]   q_s2;
	logic [PROD_W-1:0] prod;

	assign prod = {{(PROD_W-MUL_W){1'b0}}, req.a} * {{(PROD_W-MUL_W){1'b0}}, req.b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.go;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		q_s2    <= FP_W'(div_fp_one(prod_s1));
	end

	assign rsp.done = valid_s2;
	assign rsp.q    = q_s2;

endmodule

`default_nettype wire

/* design/smoothstep_rgbw_fade_engine_unit.sv */
// Channel   Handshake                       Payload
// item      item_valid / item_stall (in)    cmd, fade_kind, restart, light_on, target_*
// result    result_valid / result_stall     out_red, out_green, out_blue, out_white, fading
// config    APB write/read, pready tied     paddr, pwdata, prdata
//
// A blended frame (tick or retarget) takes the item, runs the restoring divider
// (16 iterations, then a done strobe), makes six passes of the shared multiply and
// divide-by-65535 unit, then loads the result. Fade start, fade end and fade disabled
// go straight from idle to the result load; idle ticks and dropped retargets give none.
// Reset clears the colour state and loads the register defaults; a stalled result
// holds in the output register, and the next item is taken while it waits.
`default_nettype none

module smoothstep_rgbw_fade_engine_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [srfe_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [srfe_pkg::DATA_W-1:0]    pwdata,
	output logic      [srfe_pkg::DATA_W-1:0]    prdata,
	output logic                                pready,

	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic                           cmd,
	input  wire logic [1:0]                     fade_kind,
	input  wire logic                           restart,
	input  wire logic                           light_on,
	input  wire logic [srfe_pkg::CH_W-1:0]      target_red,
	input  wire logic [srfe_pkg::CH_W-1:0]      target_green,
	input  wire logic [srfe_pkg::CH_W-1:0]      target_blue,
	input  wire logic [srfe_pkg::CH_W-1:0]      target_white,

	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic      [srfe_pkg::CH_W-1:0]      out_red,
	output logic      [srfe_pkg::CH_W-1:0]      out_green,
	output logic      [srfe_pkg::CH_W-1:0]      out_blue,
	output logic      [srfe_pkg::CH_W-1:0]      out_white,
	output logic                                fading
);
	import srfe_pkg::*;

	localparam int CH_MAX = (1 << CH_W) - 1;
	localparam logic [CH_W-1:0] LVL_CAP = CH_W'((LEVEL_MAX > CH_MAX) ? CH_MAX : LEVEL_MAX);

	function automatic logic [CH_W-1:0] clamp_lvl(input logic [CH_W-1:0] v);
		return (v > LVL_CAP) ? LVL_CAP : v;
	endfunction

	// configuration
	logic              fade_en_q;
	logic [STEP_W-1:0] steps_on_q;
	logic [STEP_W-1:0] steps_off_q;
	logic [STEP_W-1:0] steps_level_q;
	logic [STEP_W-1:0] steps_color_q;
	logic [2:0]        reg_idx;
	logic              cfg_wr;

	// fade state
	seq_state_t        state_q, state_d;
	color_t            shown_q, shown_d;
	color_t            start_q, start_d;
	color_t            goal_q, goal_d;
	logic [1:0]        kind_q, kind_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [STEP_W-1:0] total_q, total_d;
	logic              active_q, active_d;
	logic              fading_q, fading_d;

	// blend working registers
	mul_op_t           op_q, op_d;
	logic [1:0]        ch_q, ch_d;
	logic [FP_W-1:0]   t_q, t_d;
	logic [FP_W-1:0]   t2_q, t2_d;
	logic [FP_W-1:0]   s_q, s_d;

	// result register
	logic              res_valid_q;
	color_t            res_color_q;
	logic              res_fading_q;
	logic              slot_free;

	color_t            tgt;
	logic [1:0]        kind_n;
	logic [STEP_W-1:0] steps_n;
	logic              ch_up;
	logic [CH_W-1:0]   ch_diff;
	logic [CH_W-1:0]   ch_q10;

	div_req_t          div_req;
	div_rsp_t          div_rsp;
	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;

	srfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	srfe_mulq u_mulq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_en_q     <= 1'b1;
			steps_on_q    <= RST_STEPS_ON;
			steps_off_q   <= RST_STEPS_OFF;
			steps_level_q <= RST_STEPS_LEVEL;
			steps_color_q <= RST_STEPS_COLOR;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FADE_EN:     fade_en_q     <= pwdata[0];
				REG_STEPS_ON:    steps_on_q    <= pwdata[STEP_W-1:0];
				REG_STEPS_OFF:   steps_off_q   <= pwdata[STEP_W-1:0];
				REG_STEPS_LEVEL: steps_level_q <= pwdata[STEP_W-1:0];
				REG_STEPS_COLOR: steps_color_q <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FADE_EN:     prdata = {{(DATA_W-1){1'b0}}, fade_en_q};
			REG_STEPS_ON:    prdata = {{(DATA_W-STEP_W){1'b0}}, steps_on_q};
			REG_STEPS_OFF:   prdata = {{(DATA_W-STEP_W){1'b0}}, steps_off_q};
			REG_STEPS_LEVEL: prdata = {{(DATA_W-STEP_W){1'b0}}, steps_level_q};
			REG_STEPS_COLOR: prdata = {{(DATA_W-STEP_W){1'b0}}, steps_color_q};
			default:         prdata = '0;
		endcase
	end

	// ---------------- input decode ----------------
	assign tgt[0] = clamp_lvl(target_red);
	assign tgt[1] = clamp_lvl(target_green);
	assign tgt[2] = clamp_lvl(target_blue);
	assign tgt[3] = clamp_lvl(target_white);

	assign kind_n = (fade_kind == KIND_SPARE) ? KIND_LEVEL : fade_kind;

	always_comb begin
		priority if (kind_n == KIND_ONOFF)
			steps_n = light_on ? steps_on_q : steps_off_q;
		else if (kind_n == KIND_COLOR)
			steps_n = steps_color_q;
		else
			steps_n = steps_level_q;
	end

	assign ch_up   = goal_q[ch_q] >= start_q[ch_q];
	assign ch_diff = ch_up ? goal_q[ch_q] - start_q[ch_q] : start_q[ch_q] - goal_q[ch_q];
	assign ch_q10  = mul_rsp.q[CH_W-1:0];

	assign slot_free  = !res_valid_q || !result_stall;
	assign item_stall = state_q != S_IDLE;

	// ---------------- operand select for the shared unit ----------------
	always_comb begin
		mul_req.go = state_q == S_ISSUE;
		unique case (op_q)
			OP_T2: begin
				mul_req.a = {2'b0, t_q};
				mul_req.b = {2'b0, t_q};
			end
			OP_S: begin
				mul_req.a = {2'b0, t2_q};
				mul_req.b = FP_THREE - {1'b0, t_q, 1'b0};
			end
			OP_CH: begin
				mul_req.a = MUL_W'(ch_diff);
				mul_req.b = {2'b0, s_q};
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d  = state_q;
		shown_d  = shown_q;
		start_d  = start_q;
		goal_d   = goal_q;
		kind_d   = kind_q;
		step_d   = step_q;
		total_d  = total_q;
		active_d = active_q;
		fading_d = fading_q;
		op_d     = op_q;
		ch_d     = ch_q;
		t_d      = t_q;
		t2_d     = t2_q;
		s_d      = s_q;

		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (!cmd) begin
						if (active_q) begin
							step_d = step_q + 8'd1;
							if (step_d >= total_q) begin
								active_d = 1'b0;
								shown_d  = goal_q;
								fading_d = 1'b0;
								state_d  = S_EMIT;
							end else begin
								fading_d = 1'b1;
								state_d  = S_DIV;
							end
						end
					end else if (!fade_en_q) begin
						active_d = 1'b0;
						shown_d  = tgt;
						fading_d = 1'b0;
						state_d  = S_EMIT;
					end else begin
						goal_d = tgt;
						if (kind_n == KIND_COLOR && active_q && kind_q == KIND_COLOR
								&& !restart) begin
							// retarget: keep start and step, only the goal moves
							if (shown_q == tgt) begin
								active_d = 1'b0;
							end else if (total_q != '0) begin
								fading_d = 1'b1;
								state_d  = S_DIV;
							end
						end else begin
							if (!active_q || restart || kind_q != kind_n)
								start_d = shown_q;
							kind_d = kind_n;
							if (start_d == tgt) begin
								active_d = 1'b0;
								shown_d  = tgt;
								fading_d = 1'b0;
							end else begin
								// first frame of a fresh fade is the start colour
								step_d   = '0;
								total_d  = (steps_n == '0) ? 8'd1 : steps_n;
								active_d = 1'b1;
								shown_d  = start_d;
								fading_d = 1'b1;
							end
							state_d = S_EMIT;
						end
					end
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					t_d     = div_rsp.quo;
					op_d    = OP_T2;
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (mul_rsp.done) begin
					unique case (op_q)
						OP_T2: begin
							t2_d    = mul_rsp.q;
							op_d    = OP_S;
							state_d = S_ISSUE;
						end
						OP_S: begin
							s_d     = mul_rsp.q;
							op_d    = OP_CH;
							ch_d    = '0;
							state_d = S_ISSUE;
						end
						OP_CH: begin
							shown_d[ch_q] = ch_up ? start_q[ch_q] + ch_q10
								: start_q[ch_q] - ch_q10;
							if (ch_q == 2'(NCH - 1)) begin
								state_d = S_EMIT;
							end else begin
								ch_d    = ch_q + 2'd1;
								state_d = S_ISSUE;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_EMIT: begin
				if (slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		div_req.go    = (state_q == S_IDLE) && (state_d == S_DIV);
		div_req.step  = step_d;
		div_req.total = total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			shown_q  <= '0;
			start_q  <= '0;
			goal_q   <= '0;
			kind_q   <= KIND_ONOFF;
			step_q   <= '0;
			total_q  <= '0;
			active_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			shown_q  <= shown_d;
			start_q  <= start_d;
			goal_q   <= goal_d;
			kind_q   <= kind_d;
			step_q   <= step_d;
			total_q  <= total_d;
			active_q <= active_d;
		end
	end

	always_ff @(posedge clk) begin
		fading_q <= fading_d;
		op_q     <= op_d;
		ch_q     <= ch_d;
		t_q      <= t_d;
		t2_q     <= t2_d;
		s_q      <= s_d;
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && slot_free) begin
			res_color_q  <= shown_q;
			res_fading_q <= fading_q;
		end
	end

	assign result_valid = res_valid_q;
	assign out_red      = res_color_q[0];
	assign out_green    = res_color_q[1];
	assign out_blue     = res_color_q[2];
	assign out_white    = res_color_q[3];
	assign fading       = res_fading_q;

`ifndef SYNTH
	a_busy_needs_fade: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_ISSUE || state_q == S_WAIT) |-> active_q)
		else $error("blend running without an active fade");

	a_active_total: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (total_q != '0))
		else $error("active fade with zero step count");

	a_active_step: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (step_q < total_q))
		else $error("active fade step not below total");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EMIT && !res_valid_q) |=> !res_valid_q)
		else $error("result loaded outside the emit state");
`endif

endmodule

`default_nettype wire
